// ===== rtl/nlp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package nlp_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int OUT_W           = 64;
  localparam int STATUS_W        = 3;
  localparam int PHASE_W         = 3;

  // parse phases
  localparam logic [PHASE_W-1:0] PH_START   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SIGN    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_ZERO    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DIGITS  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_NAN     = 3'd4;
  localparam logic [PHASE_W-1:0] PH_BADBASE = 3'd5;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NAN   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BASE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NODIG = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNDER = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OVER  = 3'd5;

  // radix codes
  localparam logic [1:0] RX_DEC = 2'd0;
  localparam logic [1:0] RX_HEX = 2'd1;
  localparam logic [1:0] RX_OCT = 2'd2;
  localparam logic [1:0] RX_BIN = 2'd3;

  // characters
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CASE_GAP = 8'h20;
  localparam logic [7:0] LETTER_OFS_LC = 8'h57;  // 'a' - 10
  localparam logic [7:0] LETTER_OFS_UC = 8'h37;  // 'A' - 10

endpackage
`default_nettype wire

// ===== rtl/numeric_literal_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel  | signals                                   | direction
// ---------+-------------------------------------------+----------
// input    | in_valid, in_stall, char_code, last_char  | in
// result   | out_valid, out_stall, parsed_value,       | out
//          | parse_status                              |
//
// One character per cycle: input register, then one digit update (shift-add
// by the radix and a VALUE_WIDTH+4 bit range compare) into the parse state.
// A result is loaded into the output register in the same cycle that its
// last character leaves the input register. Synchronous reset clears the parse state and all
// valid flags. Only a waiting result with a stalled output holds back a
// last character; other characters keep flowing under output stall.
module numeric_literal_parser #(
  parameter int VALUE_WIDTH = nlp_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic [7:0]                    char_code,
  input  wire logic                          last_char,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic signed [nlp_pkg::OUT_W-1:0] parsed_value,
  output      logic [nlp_pkg::STATUS_W-1:0]  parse_status
);

  localparam int AW = VALUE_WIDTH + 4;
  localparam logic [AW-1:0] LimPos = {{5{1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic [AW-1:0] LimNeg = {{4{1'b0}}, 1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [VALUE_WIDTH-1:0] SatMax = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic [VALUE_WIDTH-1:0] SatMin = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  // input register
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_last;

  // parse state
  logic [nlp_pkg::PHASE_W-1:0] phase, phase_next;
  logic                        negative, negative_next;
  logic [1:0]                  radix_code, radix_code_next;
  logic [VALUE_WIDTH-1:0]      magnitude, magnitude_next;
  logic                        digit_seen, digit_seen_next;
  logic                        range_error, range_error_next;
  logic                        junk_seen, junk_seen_next;

  logic out_free;
  logic s1_go;

  logic       is_dec, is_uc, is_lc, digit_ok, in_radix, do_acc;
  logic [7:0] dval;
  logic [7:0] lc;
  logic [3:0] d4;
  logic [AW-1:0] mag_ext, prod, lim;
  logic          acc_over;

  logic [VALUE_WIDTH-1:0]          val_w;
  logic [nlp_pkg::STATUS_W-1:0]    status_next;

  assign out_free = !out_valid || !out_stall;
  assign s1_go    = s1_valid && (!s1_last || out_free);
  assign in_stall = s1_valid && !s1_go;

  // character decode
  always_comb begin
    is_dec = (s1_char >= nlp_pkg::CH_ZERO) && (s1_char <= nlp_pkg::CH_NINE);
    is_uc  = (s1_char >= nlp_pkg::CH_UA) && (s1_char <= nlp_pkg::CH_UZ);
    is_lc  = (s1_char >= nlp_pkg::CH_LA) && (s1_char <= nlp_pkg::CH_LZ);
    lc     = is_uc ? s1_char + nlp_pkg::CASE_GAP : s1_char;
    digit_ok = is_dec || is_uc || is_lc;
    if (is_dec) begin
      dval = s1_char - nlp_pkg::CH_ZERO;
    end else if (is_lc) begin
      dval = s1_char - nlp_pkg::LETTER_OFS_LC;
    end else begin
      dval = s1_char - nlp_pkg::LETTER_OFS_UC;
    end
    unique case (radix_code)
      nlp_pkg::RX_DEC: in_radix = digit_ok && (dval < 8'd10);
      nlp_pkg::RX_HEX: in_radix = digit_ok && (dval < 8'd16);
      nlp_pkg::RX_OCT: in_radix = digit_ok && (dval < 8'd8);
      nlp_pkg::RX_BIN: in_radix = digit_ok && (dval < 8'd2);
      default:         in_radix = 1'b0;
    endcase
    d4 = dval[3:0];
  end

  // multiply-accumulate by the radix, checked against the signed limit
  always_comb begin
    mag_ext = {4'b0000, magnitude};
    unique case (radix_code)
      nlp_pkg::RX_DEC: prod = (mag_ext << 3) + (mag_ext << 1);
      nlp_pkg::RX_HEX: prod = mag_ext << 4;
      nlp_pkg::RX_OCT: prod = mag_ext << 3;
      nlp_pkg::RX_BIN: prod = mag_ext << 1;
      default:         prod = mag_ext;
    endcase
    prod     = prod + {{(AW-4){1'b0}}, d4};
    lim      = negative ? LimNeg : LimPos;
    acc_over = prod > lim;
  end

  always_comb begin
    phase_next       = phase;
    negative_next    = negative;
    radix_code_next  = radix_code;
    digit_seen_next  = digit_seen;
    junk_seen_next   = junk_seen;
    do_acc           = 1'b0;
    unique case (phase)
      nlp_pkg::PH_START, nlp_pkg::PH_SIGN: begin
        priority if (phase == nlp_pkg::PH_START && s1_char == nlp_pkg::CH_MINUS) begin
          negative_next = 1'b1;
          phase_next    = nlp_pkg::PH_SIGN;
        end else if (s1_char == nlp_pkg::CH_ZERO) begin
          digit_seen_next = 1'b1;
          phase_next      = nlp_pkg::PH_ZERO;
        end else if (is_dec) begin
          do_acc     = 1'b1;
          phase_next = nlp_pkg::PH_DIGITS;
        end else if (phase == nlp_pkg::PH_START) begin
          phase_next = nlp_pkg::PH_NAN;
        end else begin
          junk_seen_next = 1'b1;
          phase_next     = nlp_pkg::PH_DIGITS;
        end
      end
      nlp_pkg::PH_ZERO: begin
        phase_next = nlp_pkg::PH_DIGITS;
        priority if (is_dec) begin
          do_acc = 1'b1;
        end else if (lc == nlp_pkg::CH_X) begin
          radix_code_next = nlp_pkg::RX_HEX;
        end else if (lc == nlp_pkg::CH_D || lc == nlp_pkg::CH_I) begin
          radix_code_next = nlp_pkg::RX_DEC;
        end else if (lc == nlp_pkg::CH_O) begin
          radix_code_next = nlp_pkg::RX_OCT;
        end else if (lc == nlp_pkg::CH_B) begin
          radix_code_next = nlp_pkg::RX_BIN;
        end else begin
          phase_next = nlp_pkg::PH_BADBASE;
        end
      end
      nlp_pkg::PH_DIGITS: begin
        if (!junk_seen) begin
          if (in_radix) do_acc = 1'b1;
          else junk_seen_next = 1'b1;
        end
      end
      default: ;
    endcase

    magnitude_next   = magnitude;
    range_error_next = range_error;
    if (do_acc) begin
      digit_seen_next = 1'b1;
      if (!range_error) begin
        if (acc_over) range_error_next = 1'b1;
        else magnitude_next = prod[VALUE_WIDTH-1:0];
      end
    end
  end

  // result from the state after this character
  always_comb begin
    val_w = '0;
    priority if (phase_next == nlp_pkg::PH_NAN) begin
      status_next = nlp_pkg::ST_NAN;
    end else if (phase_next == nlp_pkg::PH_BADBASE) begin
      status_next = nlp_pkg::ST_BASE;
    end else if (!digit_seen_next) begin
      status_next = nlp_pkg::ST_NODIG;
    end else if (range_error_next) begin
      status_next = negative_next ? nlp_pkg::ST_UNDER : nlp_pkg::ST_OVER;
      val_w       = negative_next ? SatMin : SatMax;
    end else begin
      status_next = junk_seen_next ? nlp_pkg::ST_BASE : nlp_pkg::ST_OK;
      val_w       = negative_next ? -magnitude_next : magnitude_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall) begin
      s1_char <= char_code;
      s1_last <= last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (s1_go && s1_last)) begin
      // start over for the next transaction
      phase       <= nlp_pkg::PH_START;
      negative    <= 1'b0;
      radix_code  <= nlp_pkg::RX_DEC;
      magnitude   <= '0;
      digit_seen  <= 1'b0;
      range_error <= 1'b0;
      junk_seen   <= 1'b0;
    end else if (s1_go) begin
      phase       <= phase_next;
      negative    <= negative_next;
      radix_code  <= radix_code_next;
      magnitude   <= magnitude_next;
      digit_seen  <= digit_seen_next;
      range_error <= range_error_next;
      junk_seen   <= junk_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
    if (s1_go && s1_last) begin
      parsed_value <= nlp_pkg::OUT_W'($signed(val_w));
      parse_status <= status_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/nlp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module nlp_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic [7:0]                        char_code,
  input wire logic                              last_char,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic signed [nlp_pkg::OUT_W-1:0]  parsed_value,
  input wire logic [nlp_pkg::STATUS_W-1:0]      parse_status
);

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(parsed_value) && $stable(parse_status))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> parse_status <= nlp_pkg::ST_OVER)
    else $error("status code out of range");

  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (parse_status == nlp_pkg::ST_NAN || parse_status == nlp_pkg::ST_NODIG)
    |-> parsed_value == '0)
    else $error("nonzero value without digits");

  a_sat_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && (parse_status == nlp_pkg::ST_UNDER || parse_status == nlp_pkg::ST_OVER)
    |-> parsed_value[nlp_pkg::OUT_W-1] == (parse_status == nlp_pkg::ST_UNDER))
    else $error("saturated value has wrong sign");

endmodule

bind numeric_literal_parser nlp_checker u_nlp_checker (.*);
`default_nettype wire
